@@ hw/rtl/aru_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aru_pkg: shared types, codes and GF(2^8) helpers
// s-box tables, finite field helpers and the action codes of the round unit
// ----------------------------------------------------------------------------
package aru_pkg;

  localparam int NumLanes = 4;

  typedef enum logic [2:0] {
    ACT_ENC     = 3'd0,
    ACT_ENCLAST = 3'd1,
    ACT_DEC     = 3'd2,
    ACT_DECLAST = 3'd3,
    ACT_IMC     = 3'd4,
    ACT_KEYGEN  = 3'd5
  } action_t;

  // control handed from the top level to each column lane
  typedef struct packed {
    logic inverse;
    logic do_sub;
    logic do_mix;
    logic add_key;
  } lane_ctrl_t;

  function automatic logic [7:0] xt(input logic [7:0] v);
    xt = {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    gmul = p;
  endfunction

  function automatic logic [7:0] ginv(input logic [7:0] x);
    logic [7:0] r;
    logic [7:0] b;
    r = 8'h01;
    b = x;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) r = gmul(r, b);
      b = gmul(b, b);
    end
    ginv = r;
  endfunction

  function automatic logic [7:0] rl8(input logic [7:0] v, input int n);
    rl8 = (v << n) | (v >> (8 - n));
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] b;
    b = ginv(x);
    sbox_calc = b ^ rl8(b, 1) ^ rl8(b, 2) ^ rl8(b, 3) ^ rl8(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] rsbox_calc(input logic [7:0] x);
    rsbox_calc = ginv(rl8(x, 1) ^ rl8(x, 3) ^ rl8(x, 6) ^ 8'h05);
  endfunction

  // constant tables, built at elaboration
  function automatic logic [255:0][7:0] build_sbox(input logic inverse);
    logic [255:0][7:0] t;
    for (int i = 0; i < 256; i++) begin
      t[i] = inverse ? rsbox_calc(8'(i)) : sbox_calc(8'(i));
    end
    build_sbox = t;
  endfunction

  localparam logic [255:0][7:0] SBOX  = build_sbox(1'b0);
  localparam logic [255:0][7:0] RSBOX = build_sbox(1'b1);

endpackage

@@ hw/rtl/aru_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aru_lane: one column lane
// substitution, column mixing and key add for one 32-bit column
// ----------------------------------------------------------------------------
module aru_lane import aru_pkg::*; (
  input  lane_ctrl_t  ctrl,
  input  logic [31:0] col,
  input  logic [31:0] key,
  output logic [31:0] sub,
  output logic [31:0] res
);

  logic [7:0] s [4];
  logic [7:0] m [4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      if (!ctrl.do_sub) s[r] = col[8*r +: 8];
      else if (ctrl.inverse) s[r] = RSBOX[col[8*r +: 8]];
      else s[r] = SBOX[col[8*r +: 8]];
    end
    for (int r = 0; r < 4; r++) begin
      if (ctrl.inverse) begin
        m[r] = gmul(8'd14, s[r]) ^ gmul(8'd11, s[(r+1)%4])
             ^ gmul(8'd13, s[(r+2)%4]) ^ gmul(8'd9, s[(r+3)%4]);
      end else begin
        m[r] = xt(s[r]) ^ xt(s[(r+1)%4]) ^ s[(r+1)%4] ^ s[(r+2)%4] ^ s[(r+3)%4];
      end
    end
    for (int r = 0; r < 4; r++) begin
      sub[8*r +: 8] = s[r];
      res[8*r +: 8] = (ctrl.do_mix ? m[r] : s[r]) ^ (ctrl.add_key ? key[8*r +: 8] : 8'h00);
    end
  end

endmodule

@@ hw/rtl/aru_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aru_merge: result merge
// combines lane outputs into the 128-bit result per action
// ----------------------------------------------------------------------------
module aru_merge import aru_pkg::*; (
  input  logic [2:0]   action,
  input  logic [7:0]   round_const,
  input  logic [127:0] lane_res,
  input  logic [127:0] lane_sub,
  output logic [127:0] result
);

  logic [31:0] q1;
  logic [31:0] q3;

  assign q1 = lane_sub[63:32];
  assign q3 = lane_sub[127:96];

  always_comb begin
    unique case (action)
      ACT_ENC, ACT_ENCLAST, ACT_DEC, ACT_DECLAST, ACT_IMC: result = lane_res;
      // subword, then subword rotated right by one byte with rcon in low byte
      ACT_KEYGEN: result = {{q3[7:0], q3[31:8]} ^ {24'h0, round_const}, q3,
                            {q1[7:0], q1[31:8]} ^ {24'h0, round_const}, q1};
      default: result = '0;
    endcase
  end

endmodule

@@ hw/rtl/aes_round_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_round_unit: AES round instruction unit
// one encrypt/decrypt round, inverse mixcolumns or key-generation assist
// ----------------------------------------------------------------------------
// usage:
//   input channel: in_valid/in_ready carry action, state, round key and rcon
//   output channel: out_valid/out_ready carry result_lo/result_hi
//   one result per input transfer, in order
//   result: registered, valid in the cycle after the input transfer
//   throughput: one item per cycle while out_ready is high; four column lanes run in parallel,
//     each doing substitution and mixing for one column, followed by a
//     merge stage that picks the result for the action
//   the single output register is refilled in the cycle it is drained,
//     so a new transfer is taken while a result is being taken
//   receiver stall: the output register holds, in_ready drops until taken
//   reset: output register empties; no other state
//   actions 6 and 7 return zero
// ----------------------------------------------------------------------------
module aes_round_unit import aru_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [63:0] state_lo,
  input  logic [63:0] state_hi,
  input  logic [63:0] key_lo,
  input  logic [63:0] key_hi,
  input  logic [7:0]  round_const,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] result_lo,
  output logic [63:0] result_hi
);

  logic [7:0]   sb [16];
  logic [127:0] st;
  logic [127:0] key;
  logic [127:0] shifted;
  logic [127:0] lane_in;
  logic [127:0] lane_res;
  logic [127:0] lane_sub;
  logic [127:0] merged;
  lane_ctrl_t   ctrl;
  logic         inv;

  assign st  = {state_hi, state_lo};
  assign key = {key_hi, key_lo};
  assign inv = (action == ACT_DEC) || (action == ACT_DECLAST) || (action == ACT_IMC);

  // row shift ahead of the lanes; byte i sits in column i/4, row i%4
  always_comb begin
    for (int i = 0; i < 16; i++) sb[i] = st[8*i +: 8];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) shifted[8*(r+4*c) +: 8] = sb[r + 4*((c + 4 - r) % 4)];
        else     shifted[8*(r+4*c) +: 8] = sb[r + 4*((c + r) % 4)];
      end
    end
  end

  // keygen and imc take the state unshifted
  assign lane_in = (action == ACT_IMC || action == ACT_KEYGEN) ? st : shifted;

  always_comb begin
    ctrl.inverse = inv && (action != ACT_IMC) ? 1'b1 : (action == ACT_IMC);
    ctrl.do_sub  = (action != ACT_IMC);
    ctrl.do_mix  = (action == ACT_ENC) || (action == ACT_DEC) || (action == ACT_IMC);
    ctrl.add_key = (action == ACT_ENC) || (action == ACT_ENCLAST)
                || (action == ACT_DEC) || (action == ACT_DECLAST);
    // keygen uses the forward s-box
    if (action == ACT_KEYGEN) ctrl.inverse = 1'b0;
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    aru_lane u_lane (
      .ctrl (ctrl),
      .col  (lane_in[32*g +: 32]),
      .key  (key[32*g +: 32]),
      .sub  (lane_sub[32*g +: 32]),
      .res  (lane_res[32*g +: 32])
    );
  end

  aru_merge u_merge (
    .action      (action),
    .round_const (round_const),
    .lane_res    (lane_res),
    .lane_sub    (lane_sub),
    .result      (merged)
  );

  // output register: accept when empty or being drained
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      result_lo <= merged[63:0];
      result_hi <= merged[127:64];
    end
  end

endmodule

@@ hw/rtl/aru_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aru_checker: port checker
// watches the ports of the round unit over time
// ----------------------------------------------------------------------------
module aru_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] result_lo,
  input logic [63:0] result_hi
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_lo) && $stable(result_hi))
    else $error("stalled result changed");

  // every input transfer yields a result next cycle
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("result missing after transfer");

  // ready follows output register occupancy
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("ready mismatch");

  // empty after reset
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");

endmodule

bind aes_round_unit aru_checker u_aru_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .result_lo (result_lo),
  .result_hi (result_hi)
);
